// ===== rtl/hts_pkg.sv =====
// Package for the handle table with free-slot stack.
// Holds table sizes, operation and status codes shared by the interfaces and the top level.
// No dependencies.
`default_nettype none

package hts_pkg;

  // Table geometry
  localparam int unsigned ENTRIES  = 16;
  localparam int unsigned KEY_BITS = 16;
  localparam int unsigned IDX_W    = $clog2(ENTRIES);
  localparam int unsigned CNT_W    = $clog2(ENTRIES + 1);

  // Field widths of the channels
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 4;

  // Operation codes; the remaining code is unused and reports a miss
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_LOOKUP = 2'd2
  } func_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef logic [KEY_BITS-1:0] slot_key_t;
  typedef logic [IDX_W-1:0]    slot_idx_t;
  typedef logic [CNT_W-1:0]    free_cnt_t;

endpackage

`default_nettype wire

// ===== rtl/hts_req_if.sv =====
// Request channel of the handle table: operation code and key.
// Depends on hts_pkg for field widths.
`default_nettype none

interface hts_req_if;
  logic                        valid;
  logic                        ready;
  logic [hts_pkg::FUNC_W-1:0]  func;
  logic [hts_pkg::KEY_W-1:0]   key;

  modport source (output valid, output func, output key, input ready);
  modport sink   (input valid, input func, input key, output ready);
endinterface

`default_nettype wire

// ===== rtl/hts_rsp_if.sv =====
// Response channel of the handle table: status and slot index.
// Depends on hts_pkg for field widths.
`default_nettype none

interface hts_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [hts_pkg::STATUS_W-1:0]  status;
  logic [hts_pkg::SLOT_W-1:0]    slot_index;

  modport source (output valid, output status, output slot_index, input ready);
  modport sink   (input valid, input status, input slot_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/handle_table_free_stack.sv =====
// Handle table with a LIFO stack of free slot indices.
// Depends on hts_pkg, hts_req_if and hts_rsp_if.
//
// Usage:
//   req_i carries one request per handshake: func (insert, remove, lookup)
//   and a key. rsp_o returns exactly one response per request, in order:
//   status (ok, full, not found) and the slot index, zero unless ok.
//   Insert pops the top free index and stores the key there. Remove frees
//   the lowest valid slot holding the key and pushes its index back.
//   Lookup reports the lowest valid slot holding the key.
// Timing:
//   A request is decoded, matched against all slots in parallel and the
//   table and stack are updated at the edge that accepts it; the response
//   is captured in the output register at that edge and offered from the
//   next cycle on. One request per cycle is sustained while rsp_o.ready is
//   high; the single output register sets that figure.
// Reset:
//   All slots empty, stack holds 0..ENTRIES-1 with ENTRIES-1 on top.
// Backpressure:
//   While a response waits and rsp_o.ready is low, req_i.ready is low and
//   the response holds. When the receiver takes it, a new request is
//   accepted in the same cycle.
`default_nettype none

module handle_table_free_stack (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  hts_req_if.sink     req_i,
  hts_rsp_if.source   rsp_o
);
  import hts_pkg::*;

  // Table and stack state
  slot_key_t               slot_keys_q [ENTRIES];
  logic [ENTRIES-1:0]      slot_valid_q, slot_valid_d;
  slot_idx_t               free_stack_q [ENTRIES];
  free_cnt_t               free_count_q, free_count_d;

  // Output register
  logic                    rsp_valid_q;
  status_e                 rsp_status_q, rsp_status_d;
  slot_idx_t               rsp_index_q, rsp_index_d;

  logic                    req_accept;
  slot_key_t               req_key;
  logic [ENTRIES-1:0]      match_vec;
  logic                    hit;
  slot_idx_t               hit_idx;
  slot_idx_t               top_idx;
  logic                    key_we;
  slot_idx_t               key_waddr;
  logic                    push_we;
  slot_idx_t               push_addr;

  // Accept a request whenever the output register is free or being drained
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_accept  = req_i.valid && req_i.ready;
  assign req_key     = req_i.key[KEY_BITS-1:0];

  // Compare the key against every valid slot
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = slot_valid_q[i] && (slot_keys_q[i] == req_key);
    end
  end

  // Pick the lowest matching slot
  always_comb begin
    hit_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_idx = slot_idx_t'(i);
      end
    end
  end
  assign hit = |match_vec;

  // Top of the free stack
  assign top_idx = free_stack_q[slot_idx_t'(free_count_q - free_cnt_t'(1))];

  // Decode the request and form the next state and response
  always_comb begin
    slot_valid_d = slot_valid_q;
    free_count_d = free_count_q;
    rsp_status_d = ST_MISS;
    rsp_index_d  = '0;
    key_we       = 1'b0;
    key_waddr    = top_idx;
    push_we      = 1'b0;
    push_addr    = slot_idx_t'(free_count_q);
    unique case (req_i.func)
      FN_INSERT: begin
        if (free_count_q == '0) begin
          rsp_status_d = ST_FULL;
        end else begin
          free_count_d          = free_count_q - free_cnt_t'(1);
          key_we                = 1'b1;
          slot_valid_d[top_idx] = 1'b1;
          rsp_status_d          = ST_OK;
          rsp_index_d           = top_idx;
        end
      end
      FN_REMOVE: begin
        if (hit) begin
          slot_valid_d[hit_idx] = 1'b0;
          if (free_count_q < free_cnt_t'(ENTRIES)) begin
            push_we      = 1'b1;
            free_count_d = free_count_q + free_cnt_t'(1);
          end
          rsp_status_d = ST_OK;
          rsp_index_d  = hit_idx;
        end
      end
      FN_LOOKUP: begin
        if (hit) begin
          rsp_status_d = ST_OK;
          rsp_index_d  = hit_idx;
        end
      end
      default: begin
        rsp_status_d = ST_MISS;
      end
    endcase
  end

  // Update valid bits, stack and count on an accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      free_count_q <= free_cnt_t'(ENTRIES);
      for (int i = 0; i < ENTRIES; i++) begin
        free_stack_q[i] <= slot_idx_t'(i);
      end
    end else if (req_accept) begin
      slot_valid_q <= slot_valid_d;
      free_count_q <= free_count_d;
      if (push_we) begin
        free_stack_q[push_addr] <= hit_idx;
      end
    end
  end

  // Store the key of an insert; slot contents need no reset
  always_ff @(posedge clk_i) begin
    if (req_accept && key_we) begin
      slot_keys_q[key_waddr] <= req_key;
    end
  end

  // Hold the response until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      rsp_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      rsp_status_q <= rsp_status_d;
      rsp_index_q  <= rsp_index_d;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = rsp_status_q;
  assign rsp_o.slot_index = SLOT_W'(rsp_index_q);

`ifndef ASSERT_OFF
  // Every slot is either in use or on the free stack
  a_slot_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(slot_valid_q) + int'(free_count_q)) == int'(ENTRIES))
    else $error("valid slots and free count do not add up");

  // An insert into an empty stack reports full
  a_insert_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_accept && req_i.func == FN_INSERT && free_count_q == '0)
      |=> (rsp_status_q == ST_FULL && rsp_index_q == '0))
    else $error("insert on a full table not reported as full");

  // A successful insert leaves its slot valid
  a_insert_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_accept && req_i.func == FN_INSERT && free_count_q != '0)
      |=> slot_valid_q[rsp_index_q])
    else $error("inserted slot not marked valid");

  // A successful remove leaves its slot free
  a_remove_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_accept && req_i.func == FN_REMOVE && hit)
      |=> (!slot_valid_q[rsp_index_q] && rsp_status_q == ST_OK))
    else $error("removed slot still valid");
`endif

endmodule

`default_nettype wire

// ===== test/handle_table_free_stack_tb.sv =====
// Self-checking testbench for the handle table with free-slot stack.
// Drives insert, remove and lookup requests and checks each response against a table model.
// Depends on hts_pkg, hts_req_if, hts_rsp_if and handle_table_free_stack.
`default_nettype none

module handle_table_free_stack_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hts_pkg::*;

  // The fourth operation code is unused by the block and reports a miss
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  localparam int unsigned CYCLE_LIMIT = 50000;
  localparam int unsigned HOLD_AT     = 350;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned CALM_FROM   = 450;
  localparam int unsigned CALM_TO     = 560;
  localparam int unsigned IDLE_PCT    = 12;

  typedef struct {
    logic              drain;
    logic [FUNC_W-1:0] func;
    slot_key_t         key;
  } req_item_t;

  typedef struct {
    status_e   status;
    slot_idx_t slot_index;
  } rsp_item_t;

  logic clk_i;
  logic rst_ni;

  hts_req_if req_if ();
  hts_rsp_if rsp_if ();

  handle_table_free_stack i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Table model state
  slot_key_t tbl_key   [ENTRIES];
  logic      tbl_valid [ENTRIES];
  slot_idx_t free_stk  [ENTRIES];
  free_cnt_t free_top;

  req_item_t   pending_q[$];
  rsp_item_t   rsp_expect_q[$];
  int unsigned req_accept_cnt;
  int unsigned err_cnt;

  // Apply one request to the table model and return the response it causes
  task automatic apply_to_table(input logic [FUNC_W-1:0] fn, input slot_key_t k,
                                output status_e st, output slot_idx_t ix);
    int hit;
    hit = -1;
    st  = ST_MISS;
    ix  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_key[i] == k) hit = i;
    end
    case (fn)
      FN_INSERT: begin
        if (free_top == 0) begin
          st = ST_FULL;
        end else begin
          free_top = free_top - 1'b1;
          ix = free_stk[slot_idx_t'(free_top)];
          tbl_key[ix]   = k;
          tbl_valid[ix] = 1'b1;
          st = ST_OK;
        end
      end
      FN_REMOVE: begin
        if (hit >= 0) begin
          tbl_valid[hit]     = 1'b0;
          free_stk[slot_idx_t'(free_top)] = slot_idx_t'(hit);
          free_top = free_top + 1'b1;
          st = ST_OK;
          ix = slot_idx_t'(hit);
        end
      end
      FN_LOOKUP: begin
        if (hit >= 0) begin
          st = ST_OK;
          ix = slot_idx_t'(hit);
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_req(input logic [FUNC_W-1:0] fn, input slot_key_t k);
    req_item_t itm;
    itm.drain = 1'b0;
    itm.func  = fn;
    itm.key   = k;
    pending_q.push_back(itm);
  endtask

  // Marker: sender waits until every response has come back
  task automatic push_drain();
    req_item_t itm;
    itm.drain = 1'b1;
    itm.func  = FN_INSERT;
    itm.key   = '0;
    pending_q.push_back(itm);
  endtask

  function automatic logic idle_now();
    logic calm;
    calm = (req_accept_cnt >= CALM_FROM) && (req_accept_cnt < CALM_TO);
    return !calm && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Reset, model init and stimulus
  initial begin
    slot_key_t         key_pool [12];
    logic [FUNC_W-1:0] fn;
    slot_key_t         k;
    int unsigned       roll;

    rst_ni        = 1'b0;
    req_if.valid  = 1'b0;
    req_if.func   = '0;
    req_if.key    = '0;
    rsp_if.ready  = 1'b0;
    req_accept_cnt = 0;
    err_cnt        = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_key[i]   = '0;
      tbl_valid[i] = 1'b0;
      free_stk[i]  = slot_idx_t'(i);
    end
    free_top = free_cnt_t'(ENTRIES);

    // Directed: misses on an empty table, unused code, fill past full,
    // duplicates and the all-ones key
    push_req(FN_LOOKUP, 16'hFFFF);
    push_req(FN_REMOVE, 16'h0000);
    push_req(FN_UNUSED, 16'h1234);
    push_req(FN_INSERT, 16'hFFFF);
    push_req(FN_INSERT, 16'h0000);
    push_req(FN_INSERT, 16'h5555);
    push_req(FN_INSERT, 16'h5555);
    push_req(FN_INSERT, 16'hAAAA);
    for (int i = 0; i < 11; i++) push_req(FN_INSERT, slot_key_t'(16'h0100 + i));
    push_req(FN_INSERT, 16'h7777);
    push_req(FN_LOOKUP, 16'h5555);
    push_req(FN_REMOVE, 16'h5555);
    push_req(FN_LOOKUP, 16'h5555);
    push_req(FN_REMOVE, 16'hFFFF);
    push_req(FN_LOOKUP, 16'hFFFF);
    push_drain();

    // Random: a small key pool keeps hits frequent, full random keys toggle
    // every bit; blocks alternate between filling and draining the table
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < 12; i++) key_pool[i] = slot_key_t'($urandom);
    for (int b = 0; b < 6; b++) begin
      if (b == 3) push_drain();
      for (int n = 0; n < 100; n++) begin
        roll = $urandom_range(99);
        if (b % 2 == 0) begin
          fn = (roll < 60) ? FN_INSERT : (roll < 80) ? FN_REMOVE :
               (roll < 95) ? FN_LOOKUP : FN_UNUSED;
        end else begin
          fn = (roll < 20) ? FN_INSERT : (roll < 75) ? FN_REMOVE :
               (roll < 95) ? FN_LOOKUP : FN_UNUSED;
        end
        if ($urandom_range(99) < 25) k = slot_key_t'($urandom);
        else k = key_pool[$urandom_range(11)];
        push_req(fn, k);
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for all requests, then all responses, then a short tail
    while (pending_q.size() != 0 || req_if.valid) @(posedge clk_i);
    while (rsp_expect_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (rsp_expect_q.size() != 0) begin
      $display("%0t: %0d responses never arrived", $realtime, rsp_expect_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Timeout
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t: timeout", $realtime);
    $display("RESULT: ERROR");
    $finish;
  end

  // Request driver: hold until taken, honor drain markers, idle at random
  always @(negedge clk_i) begin
    logic              nxt_valid;
    logic [FUNC_W-1:0] nxt_func;
    slot_key_t         nxt_key;
    int unsigned       seen_cnt;
    req_item_t         itm;
    nxt_valid = req_if.valid;
    nxt_func  = req_if.func;
    nxt_key   = req_if.key;
    if (rst_ni && !(req_if.valid && req_accept_cnt == seen_cnt)) begin
      seen_cnt  = req_accept_cnt;
      nxt_valid = 1'b0;
      if (pending_q.size() != 0) begin
        itm = pending_q[0];
        if (itm.drain) begin
          if (rsp_expect_q.size() == 0) void'(pending_q.pop_front());
        end else if (!idle_now()) begin
          void'(pending_q.pop_front());
          nxt_valid = 1'b1;
          nxt_func  = itm.func;
          nxt_key   = itm.key;
        end
      end
    end
    req_if.valid <= nxt_valid;
    req_if.func  <= nxt_func;
    req_if.key   <= nxt_key;
  end

  // Response receiver: one long hold-off, otherwise random stalls
  always @(negedge clk_i) begin
    logic        nxt_ready;
    logic        hold_done;
    int unsigned hold_left;
    if (hold_done !== 1'b1 && req_accept_cnt >= HOLD_AT) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      nxt_ready = 1'b0;
    end else begin
      nxt_ready = rst_ni && !idle_now();
    end
    rsp_if.ready <= nxt_ready;
  end

  // Monitor: check the response leaving, then predict the request entering
  always @(posedge clk_i) begin
    rsp_item_t exp_rsp;
    status_e   st;
    slot_idx_t ix;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (rsp_expect_q.size() == 0) begin
          $display("%0t: unexpected response status %0d slot %0d", $realtime,
                   rsp_if.status, rsp_if.slot_index);
          err_cnt++;
        end else begin
          exp_rsp = rsp_expect_q.pop_front();
          if (rsp_if.status !== exp_rsp.status) begin
            $display("%0t: status mismatch expected %0d actual %0d", $realtime,
                     exp_rsp.status, rsp_if.status);
            err_cnt++;
          end
          if (rsp_if.slot_index !== exp_rsp.slot_index) begin
            $display("%0t: slot_index mismatch expected %0d actual %0d", $realtime,
                     exp_rsp.slot_index, rsp_if.slot_index);
            err_cnt++;
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        apply_to_table(req_if.func, req_if.key, st, ix);
        exp_rsp.status     = st;
        exp_rsp.slot_index = ix;
        rsp_expect_q.push_back(exp_rsp);
        req_accept_cnt++;
      end
    end
  end

endmodule

`default_nettype wire
